@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the line rasterizer.
// Checks compile only when SYNTHESIS is not defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every clock edge outside reset.
`define CLR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("clipped line rasterizer check failed");

// Checked at every clock edge, reset included.
`define CLR_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("clipped line rasterizer check failed during reset");

`else

`define CLR_ASSERT(lbl, prop)
`define CLR_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

@@ sv/clr_pkg.sv @@
// ----------------------------------------------------------------------------
// clr_pkg
// Shared widths, codes and types of the clipped line rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package clr_pkg;

	localparam int COORD_BITS    = 12;
	localparam int PIX_BITS      = COORD_BITS + 1;
	localparam int EDGE_BITS     = COORD_BITS + 2;
	localparam int ERR_BITS      = COORD_BITS + 2;
	localparam int COLOR_BITS    = 32;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [PIX_BITS-1:0]   pix_t;

	// Command codes carried by the func field.
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_STEP = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_X    = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_OFFSET_Y    = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_LEFT   = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_TOP    = CFG_IDX_BITS'(3);
	localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_WIDTH  = CFG_IDX_BITS'(4);
	localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_HEIGHT = CFG_IDX_BITS'(5);
	localparam logic [CFG_IDX_BITS-1:0] REG_PEN_COLOR   = CFG_IDX_BITS'(6);

	localparam logic [COORD_BITS-1:0] CLIP_WIDTH_RST  = COORD_BITS'(480);
	localparam logic [COORD_BITS-1:0] CLIP_HEIGHT_RST = COORD_BITS'(240);
	localparam logic [COLOR_BITS-1:0] PEN_COLOR_RST   = '1;

	typedef struct packed {
		coord_t                  offset_x;
		coord_t                  offset_y;
		coord_t                  clip_left;
		coord_t                  clip_top;
		logic [COORD_BITS-1:0]   clip_width;
		logic [COORD_BITS-1:0]   clip_height;
		logic [COLOR_BITS-1:0]   pen_color;
	} cfg_t;

	typedef struct packed {
		logic running;
		logic last;
	} step_status_t;

endpackage

`default_nettype wire

@@ sv/clr_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// clr_cfg_regs
// Write-only configuration registers: origin, clip rectangle and pen color.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clr_cfg_regs import clr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output cfg_t                     cfg
);

	cfg_t cfg_q;
	logic [COORD_BITS-1:0] coord_data;

	assign coord_data = cfg_data[COORD_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_x    <= '0;
			cfg_q.offset_y    <= '0;
			cfg_q.clip_left   <= '0;
			cfg_q.clip_top    <= '0;
			cfg_q.clip_width  <= CLIP_WIDTH_RST;
			cfg_q.clip_height <= CLIP_HEIGHT_RST;
			cfg_q.pen_color   <= PEN_COLOR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OFFSET_X:    cfg_q.offset_x    <= coord_data;
				REG_OFFSET_Y:    cfg_q.offset_y    <= coord_data;
				REG_CLIP_LEFT:   cfg_q.clip_left   <= coord_data;
				REG_CLIP_TOP:    cfg_q.clip_top    <= coord_data;
				REG_CLIP_WIDTH:  cfg_q.clip_width  <= coord_data;
				REG_CLIP_HEIGHT: cfg_q.clip_height <= coord_data;
				REG_PEN_COLOR:   cfg_q.pen_color   <= cfg_data[COLOR_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ sv/clr_stepper.sv @@
// ----------------------------------------------------------------------------
// clr_stepper
// Bresenham state for all octants: set up on a load, one update per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clr_stepper import clr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  logic         step,
	input  coord_t       x0_in,
	input  coord_t       y0_in,
	input  coord_t       x1_in,
	input  coord_t       y1_in,
	output coord_t       cur_x,
	output coord_t       cur_y,
	output step_status_t status
);

	coord_t                      cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	logic [COORD_BITS-1:0]       span_x_q;
	logic signed [COORD_BITS:0]  span_y_neg_q;
	logic signed [ERR_BITS-1:0]  err_q;
	logic                        dir_x_neg_q, dir_y_neg_q, running_q;

	// Load setup.
	logic                        swap;
	coord_t                      lx0, ly0, lx1, ly1;
	pix_t                        dx_full, dy_full, dx_abs, dy_abs;

	// Step update.
	logic signed [ERR_BITS:0]    e2, err_acc, span_x_ext;
	logic                        at_end, x_ok, x_hit, x_move, y_ok, y_hit, y_move, last;
	coord_t                      next_x, next_y;

	always_comb begin
		swap    = y0_in > y1_in;
		lx0     = swap ? x1_in : x0_in;
		ly0     = swap ? y1_in : y0_in;
		lx1     = swap ? x0_in : x1_in;
		ly1     = swap ? y0_in : y1_in;
		dx_full = PIX_BITS'(lx1) - PIX_BITS'(lx0);
		dy_full = PIX_BITS'(ly1) - PIX_BITS'(ly0);
		dx_abs  = dx_full[PIX_BITS-1] ? -dx_full : dx_full;
		dy_abs  = dy_full[PIX_BITS-1] ? -dy_full : dy_full;
	end

	always_comb begin
		span_x_ext = $signed({{(ERR_BITS+1-COORD_BITS){1'b0}}, span_x_q});
		e2         = {err_q, 1'b0};
		at_end     = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
		x_ok       = !at_end && (e2 >= (ERR_BITS+1)'(span_y_neg_q));
		x_hit      = x_ok && (cur_x_q == tgt_x_q);
		x_move     = x_ok && !x_hit;
		// The y move is only looked at when the x check did not end the line.
		y_ok       = !at_end && !x_hit && (e2 <= span_x_ext);
		y_hit      = y_ok && (cur_y_q == tgt_y_q);
		y_move     = y_ok && !y_hit;
		last       = at_end || x_hit || y_hit;

		err_acc = (ERR_BITS+1)'(err_q);
		if (x_move)
			err_acc = err_acc + (ERR_BITS+1)'(span_y_neg_q);
		if (y_move)
			err_acc = err_acc + span_x_ext;

		next_x = dir_x_neg_q ? cur_x_q - coord_t'(1) : cur_x_q + coord_t'(1);
		next_y = dir_y_neg_q ? cur_y_q - coord_t'(1) : cur_y_q + coord_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			tgt_x_q      <= '0;
			tgt_y_q      <= '0;
			span_x_q     <= '0;
			span_y_neg_q <= '0;
			err_q        <= '0;
			dir_x_neg_q  <= 1'b0;
			dir_y_neg_q  <= 1'b0;
			running_q    <= 1'b0;
		end else if (load) begin
			cur_x_q      <= lx0;
			cur_y_q      <= ly0;
			tgt_x_q      <= lx1;
			tgt_y_q      <= ly1;
			span_x_q     <= dx_abs[COORD_BITS-1:0];
			span_y_neg_q <= -dy_abs;
			err_q        <= ERR_BITS'(dx_abs) - ERR_BITS'(dy_abs);
			dir_x_neg_q  <= !(lx0 < lx1);
			dir_y_neg_q  <= !(ly0 < ly1);
			running_q    <= 1'b1;
		end else if (step && running_q) begin
			if (x_move)
				cur_x_q <= next_x;
			if (y_move)
				cur_y_q <= next_y;
			err_q     <= err_acc[ERR_BITS-1:0];
			running_q <= !last;
		end
	end

	assign cur_x          = cur_x_q;
	assign cur_y          = cur_y_q;
	assign status.running = running_q;
	assign status.last    = last;

endmodule

`default_nettype wire

@@ sv/clr_clip.sv @@
// ----------------------------------------------------------------------------
// clr_clip
// Screen position of the current point and its clip rectangle test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clr_clip import clr_pkg::*; (
	input  coord_t cur_x,
	input  coord_t cur_y,
	input  cfg_t   cfg,
	output pix_t   pixel_x,
	output pix_t   pixel_y,
	output logic   visible
);

	logic signed [EDGE_BITS-1:0] sx, sy, left, top, right, bottom;

	assign pixel_x = PIX_BITS'(cur_x) + PIX_BITS'(cfg.offset_x);
	assign pixel_y = PIX_BITS'(cur_y) + PIX_BITS'(cfg.offset_y);

	// Edges are compared at full width, so the right and bottom sums never wrap.
	assign sx     = EDGE_BITS'(pixel_x);
	assign sy     = EDGE_BITS'(pixel_y);
	assign left   = EDGE_BITS'(cfg.clip_left);
	assign top    = EDGE_BITS'(cfg.clip_top);
	assign right  = left + $signed({{(EDGE_BITS-COORD_BITS){1'b0}}, cfg.clip_width});
	assign bottom = top + $signed({{(EDGE_BITS-COORD_BITS){1'b0}}, cfg.clip_height});

	assign visible = (sx >= left) && (sx < right) && (sy >= top) && (sy < bottom);

endmodule

`default_nettype wire

@@ sv/clipped_line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// clipped_line_rasterizer
// A load command (func = 0) sets up a line between two endpoints, ordered so
// that it runs downward on the screen; each step command (func = 1) returns
// one pixel beat with the screen position (point plus origin), the pen color,
// a visible flag from the inclusive-left, inclusive-top clip rectangle, and a
// last flag on the final pixel. Loads and steps with no line in progress give
// no beat. The block takes one command per clock while cmd_ready is high: a
// command is registered on acceptance, and the Bresenham update then runs
// into the pixel register once that register is free or its beat is taken.
// The input register also serves as a skid stage, so one more command is taken
// while a pixel beat waits; cmd_ready drops only when both registers are full.
// Configuration writes take effect on the next clock.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module clipped_line_rasterizer import clr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     cmd_valid,
	output logic                     cmd_ready,
	input  logic                     func,
	input  coord_t                   start_x,
	input  coord_t                   start_y,
	input  coord_t                   end_x,
	input  coord_t                   end_y,
	output logic                     px_valid,
	input  logic                     px_ready,
	output pix_t                     pixel_x,
	output pix_t                     pixel_y,
	output logic [COLOR_BITS-1:0]    color,
	output logic                     visible,
	output logic                     last
);

	cfg_t         cfg;
	step_status_t status;
	coord_t       cur_x, cur_y;
	pix_t         scr_x, scr_y;
	logic         scr_visible;

	logic         valid_s1, func_s1;
	coord_t       start_x_s1, start_y_s1, end_x_s1, end_y_s1;
	logic         accept, fire_s1, load, step, emit;

	logic                  px_valid_q, visible_q, last_q;
	pix_t                  pixel_x_q, pixel_y_q;
	logic [COLOR_BITS-1:0] color_q;

	assign accept    = cmd_valid && cmd_ready;
	assign fire_s1   = valid_s1 && (!px_valid_q || px_ready);
	assign cmd_ready = !valid_s1 || !px_valid_q || px_ready;
	assign load      = fire_s1 && (func_s1 == FUNC_LOAD);
	assign step      = fire_s1 && (func_s1 == FUNC_STEP);
	assign emit      = step && status.running;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (fire_s1)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1    <= func;
			start_x_s1 <= start_x;
			start_y_s1 <= start_y;
			end_x_s1   <= end_x;
			end_y_s1   <= end_y;
		end
	end

	clr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	clr_stepper u_stepper (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.step   (step),
		.x0_in  (start_x_s1),
		.y0_in  (start_y_s1),
		.x1_in  (end_x_s1),
		.y1_in  (end_y_s1),
		.cur_x  (cur_x),
		.cur_y  (cur_y),
		.status (status)
	);

	clr_clip u_clip (
		.cur_x   (cur_x),
		.cur_y   (cur_y),
		.cfg     (cfg),
		.pixel_x (scr_x),
		.pixel_y (scr_y),
		.visible (scr_visible)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			px_valid_q <= 1'b0;
		else if (emit)
			px_valid_q <= 1'b1;
		else if (px_ready)
			px_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pixel_x_q <= scr_x;
			pixel_y_q <= scr_y;
			color_q   <= cfg.pen_color;
			visible_q <= scr_visible;
			last_q    <= status.last;
		end
	end

	assign px_valid = px_valid_q;
	assign pixel_x  = pixel_x_q;
	assign pixel_y  = pixel_y_q;
	assign color    = color_q;
	assign visible  = visible_q;
	assign last     = last_q;

	// After the last pixel of a line the stepper is idle until the next load.
	`CLR_ASSERT(a_idle_after_last, (emit && status.last) |=> !status.running)
	// A step with no line in progress leaves the pixel register empty.
	`CLR_ASSERT(a_idle_step_silent, (step && !status.running) |=> !px_valid)
	// Backpressure reaches the command side only when both registers are full.
	`CLR_ASSERT(a_ready_low_full, !cmd_ready |-> (valid_s1 && px_valid_q && !px_ready))
	// An edge seen in reset leaves both registers empty by the following edge.
	`CLR_ASSERT_ALWAYS(a_reset_no_beat, !arst_n |=> (!px_valid && !valid_s1))

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clipped line rasterizer testbench
// Drives load and step commands into the rasterizer, keeps a bit-accurate
// line stepper of its own that predicts every pixel beat, and compares each
// beat field by field. Directed lines cover octants of both slopes, endpoint swapping,
// restarts, extreme coordinates and clip settings; random lines follow under
// three mixes of sender and receiver idling.
// ----------------------------------------------------------------------------

module testbench;
	import clr_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int RESET_CYCLES  = 7;
	localparam int SETTLE_CYCLES = 6;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int PHASE_ITEMS   = 150;
	localparam int FULL_LINE     = 8192;
	localparam int COORD_MIN     = -(2 ** (COORD_BITS - 1));
	localparam int COORD_MAX     = 2 ** (COORD_BITS - 1) - 1;
	localparam logic [CFG_IDX_BITS-1:0] REG_UNMAPPED = CFG_IDX_BITS'(7);

	typedef struct {
		pix_t                  x;
		pix_t                  y;
		logic [COLOR_BITS-1:0] color;
		logic                  vis;
		logic                  last;
	} pixel_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     cfg_we    = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
	logic                     cmd_valid = 1'b0;
	logic                     cmd_ready;
	logic                     func      = FUNC_LOAD;
	coord_t                   start_x   = '0;
	coord_t                   start_y   = '0;
	coord_t                   end_x     = '0;
	coord_t                   end_y     = '0;
	logic                     px_valid;
	logic                     px_ready  = 1'b0;
	pix_t                     pixel_x;
	pix_t                     pixel_y;
	logic [COLOR_BITS-1:0]    color;
	logic                     visible;
	logic                     last;

	// Register shadow and line stepper state of the predictor.
	cfg_t                        regs_now;
	coord_t                      ln_x = '0, ln_y = '0, ln_tx = '0, ln_ty = '0;
	logic [COORD_BITS-1:0]       ln_span_x = '0;
	logic signed [PIX_BITS-1:0]  ln_span_y_neg = '0;
	logic signed [ERR_BITS-1:0]  ln_err = '0;
	logic                        ln_dir_x_neg = 1'b0, ln_dir_y_neg = 1'b0;
	logic                        ln_running = 1'b0;

	pixel_t expected_pixels[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int sent_items    = 0;
	int lines_loaded  = 0;
	int beats_checked = 0;
	int beats_visible = 0;
	int error_count   = 0;
	int cycle_count   = 0;

	clipped_line_rasterizer DUT (.*);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Applies one accepted command to the line stepper and queues the pixel it yields.
	task automatic advance_line(input logic f, input coord_t x0, input coord_t y0,
			input coord_t x1, input coord_t y1);
		int ax, ay, bx, by, dx, dy, sx, sy, left, top, e2, span_x, span_y_neg, err;
		logic done;
		pixel_t px;
		if (f == FUNC_LOAD) begin
			ax = x0;
			ay = y0;
			bx = x1;
			by = y1;
			// Lines always run downward on the screen.
			if (ay > by) begin
				ax = x1;
				ay = y1;
				bx = x0;
				by = y0;
			end
			dx = (bx > ax) ? bx - ax : ax - bx;
			dy = (by > ay) ? by - ay : ay - by;
			ln_x = coord_t'(ax);
			ln_y = coord_t'(ay);
			ln_tx = coord_t'(bx);
			ln_ty = coord_t'(by);
			ln_span_x = COORD_BITS'(dx);
			ln_span_y_neg = PIX_BITS'(-dy);
			ln_err = ERR_BITS'(dx - dy);
			ln_dir_x_neg = !(ax < bx);
			ln_dir_y_neg = !(ay < by);
			ln_running = 1'b1;
			lines_loaded++;
		end else if (ln_running) begin
			sx = int'(ln_x) + int'(regs_now.offset_x);
			sy = int'(ln_y) + int'(regs_now.offset_y);
			left = int'(regs_now.clip_left);
			top = int'(regs_now.clip_top);
			px.vis = (sx >= left) && (sx < left + int'(regs_now.clip_width)) &&
				(sy >= top) && (sy < top + int'(regs_now.clip_height));
			done = (ln_x == ln_tx) && (ln_y == ln_ty);
			if (!done) begin
				err = int'(ln_err);
				e2 = 2 * err;
				span_x = int'(ln_span_x);
				span_y_neg = int'(ln_span_y_neg);
				if (e2 >= span_y_neg) begin
					if (ln_x == ln_tx) begin
						done = 1'b1;
					end else begin
						err += span_y_neg;
						ln_x = coord_t'(int'(ln_x) + (ln_dir_x_neg ? -1 : 1));
					end
				end
				if (!done && e2 <= span_x) begin
					if (ln_y == ln_ty) begin
						done = 1'b1;
					end else begin
						err += span_x;
						ln_y = coord_t'(int'(ln_y) + (ln_dir_y_neg ? -1 : 1));
					end
				end
				ln_err = ERR_BITS'(err);
			end
			if (done) ln_running = 1'b0;
			px.x = PIX_BITS'(sx);
			px.y = PIX_BITS'(sy);
			px.color = regs_now.pen_color;
			px.last = done;
			expected_pixels.push_back(px);
		end
	endtask

	// Entered and left just after a rising edge; valid stays up after the beat.
	task automatic send_cmd(input logic f, input coord_t x0, input coord_t y0,
			input coord_t x1, input coord_t y1);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		func <= f;
		start_x <= x0;
		start_y <= y0;
		end_x <= x1;
		end_y <= y1;
		@(posedge clk);
		while (cmd_ready !== 1'b1) @(posedge clk);
		if (f == FUNC_LOAD || ln_running) sent_items++;
		advance_line(f, x0, y0, x1, y1);
	endtask

	// Endpoint fields of a step are ignored, so they carry random bits.
	task automatic step_pen();
		send_cmd(FUNC_STEP, coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom), coord_t'($urandom));
	endtask

	task automatic draw_line(input int x0, input int y0, input int x1,
			input int y1, input int max_steps);
		int n;
		send_cmd(FUNC_LOAD, coord_t'(x0), coord_t'(y0), coord_t'(x1), coord_t'(y1));
		n = 0;
		while (ln_running && n < max_steps) begin
			step_pen();
			n++;
		end
	endtask

	task automatic settle();
		cmd_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Bits above a coordinate register's width are filled with noise.
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		logic [CFG_DATA_BITS-1:0] data;
		data = value;
		if (idx != REG_PEN_COLOR)
			data[CFG_DATA_BITS-1:COORD_BITS] = (CFG_DATA_BITS - COORD_BITS)'($urandom);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_OFFSET_X:    regs_now.offset_x = coord_t'(data[COORD_BITS-1:0]);
			REG_OFFSET_Y:    regs_now.offset_y = coord_t'(data[COORD_BITS-1:0]);
			REG_CLIP_LEFT:   regs_now.clip_left = coord_t'(data[COORD_BITS-1:0]);
			REG_CLIP_TOP:    regs_now.clip_top = coord_t'(data[COORD_BITS-1:0]);
			REG_CLIP_WIDTH:  regs_now.clip_width = data[COORD_BITS-1:0];
			REG_CLIP_HEIGHT: regs_now.clip_height = data[COORD_BITS-1:0];
			REG_PEN_COLOR:   regs_now.pen_color = data;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic coord_t near_coord(input coord_t c, input int spread);
		int v;
		v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < COORD_MIN) v = COORD_MIN;
		if (v > COORD_MAX) v = COORD_MAX;
		return coord_t'(v);
	endfunction

	always @(posedge clk) begin : pixel_check
		pixel_t want;
		if (arst_n && px_valid === 1'b1 && px_ready) begin
			if (expected_pixels.size() == 0) begin
				$error("pixel beat with nothing pending: x=%0d y=%0d", pixel_x, pixel_y);
				error_count++;
			end else begin
				want = expected_pixels.pop_front();
				beats_checked++;
				if (want.vis) beats_visible++;
				if (pixel_x !== want.x) begin
					$error("pixel_x: expected %0d, got %0d", want.x, pixel_x);
					error_count++;
				end
				if (pixel_y !== want.y) begin
					$error("pixel_y: expected %0d, got %0d", want.y, pixel_y);
					error_count++;
				end
				if (color !== want.color) begin
					$error("color: expected %h, got %h", want.color, color);
					error_count++;
				end
				if (visible !== want.vis) begin
					$error("visible: expected %b, got %b", want.vis, visible);
					error_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %b, got %b", want.last, last);
					error_count++;
				end
			end
		end
		px_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	task automatic test_idle_steps_and_points();
		step_pen();
		draw_line(5, 5, 5, 5, FULL_LINE);
		step_pen();
	endtask

	task automatic test_octants();
		draw_line(0, 0, 2, 1, FULL_LINE);
		draw_line(0, 0, -1, -2, FULL_LINE);
		draw_line(0, 0, -2, 1, FULL_LINE);
	endtask

	// A load in the middle of a line drops the rest of it.
	task automatic test_line_restart();
		draw_line(10, 10, 14, 12, 1);
		draw_line(-3, -3, -3, -3, FULL_LINE);
	endtask

	task automatic test_field_extremes();
		draw_line(COORD_MIN, COORD_MAX, COORD_MIN + 1, COORD_MAX, FULL_LINE);
		draw_line(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN + 1, FULL_LINE);
	endtask

	task automatic test_register_extremes();
		settle();
		write_reg(REG_OFFSET_X, COORD_MIN);
		write_reg(REG_OFFSET_Y, COORD_MAX);
		write_reg(REG_CLIP_LEFT, COORD_MIN);
		write_reg(REG_CLIP_TOP, COORD_MIN);
		write_reg(REG_CLIP_WIDTH, 4095);
		write_reg(REG_CLIP_HEIGHT, 4095);
		write_reg(REG_PEN_COLOR, '0);
		draw_line(COORD_MIN, COORD_MAX, COORD_MIN + 1, COORD_MAX - 1, FULL_LINE);
		draw_line(COORD_MAX, COORD_MIN, COORD_MAX - 1, COORD_MIN + 1, FULL_LINE);
		settle();
		// The right edge sum runs past the coordinate range and must not wrap.
		write_reg(REG_OFFSET_X, COORD_MAX);
		write_reg(REG_OFFSET_Y, COORD_MIN);
		write_reg(REG_CLIP_LEFT, COORD_MAX);
		write_reg(REG_PEN_COLOR, '1);
		draw_line(COORD_MAX, COORD_MAX, COORD_MAX - 2, COORD_MAX - 1, FULL_LINE);
		draw_line(COORD_MIN, 0, COORD_MIN + 1, 1, FULL_LINE);
		settle();
		write_reg(REG_CLIP_WIDTH, 0);
		write_reg(REG_UNMAPPED, $urandom);
		draw_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX - 1, FULL_LINE);
		settle();
		write_reg(REG_CLIP_WIDTH, 4095);
		write_reg(REG_CLIP_HEIGHT, 0);
		draw_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX - 1, FULL_LINE);
	endtask

	// Mostly complete short lines near the clip window, with some long lines
	// cut short, restarts and steps that land on an idle stepper.
	task automatic test_random_phase(input int s_pct, input int r_pct, input int items);
		int first, pick, spread, max_steps;
		coord_t ax, ay;
		settle();
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		write_reg(REG_OFFSET_X, $urandom_range(0, 128) - 64);
		write_reg(REG_OFFSET_Y, $urandom_range(0, 128) - 64);
		write_reg(REG_CLIP_LEFT, $urandom_range(0, 300) - 300);
		write_reg(REG_CLIP_TOP, $urandom_range(0, 300) - 300);
		write_reg(REG_CLIP_WIDTH, $urandom_range(50, 600));
		write_reg(REG_CLIP_HEIGHT, $urandom_range(50, 600));
		write_reg(REG_PEN_COLOR, $urandom);
		first = sent_items;
		while (sent_items - first < items) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				step_pen();
			end else if (pick < 10) begin
				draw_line(int'($urandom), int'($urandom), int'($urandom),
					int'($urandom), $urandom_range(10, 60));
			end else begin
				ax = (pick < 70) ? near_coord('0, 300) : coord_t'($urandom);
				ay = (pick < 70) ? near_coord('0, 300) : coord_t'($urandom);
				spread = ($urandom_range(0, 9) < 8) ? 12 : 120;
				max_steps = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6) : FULL_LINE;
				draw_line(int'(ax), int'(ay), int'(near_coord(ax, spread)),
					int'(near_coord(ay, spread)), max_steps);
			end
		end
	endtask

	initial begin
		regs_now = '{offset_x: '0, offset_y: '0, clip_left: '0, clip_top: '0,
			clip_width: CLIP_WIDTH_RST, clip_height: CLIP_HEIGHT_RST,
			pen_color: PEN_COLOR_RST};
		send_idle_pct = 8;
		recv_idle_pct = 62;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_steps_and_points();
		test_octants();
		test_line_restart();
		test_field_extremes();
		test_register_extremes();
		test_random_phase(8, 62, PHASE_ITEMS);
		test_random_phase(62, 8, PHASE_ITEMS);
		test_random_phase(0, 0, PHASE_ITEMS);
		settle();
		$display("Loaded %0d lines and sent %0d active commands under three idling mixes.",
			lines_loaded, sent_items);
		$display("Checked %0d pixel beats, %0d of them inside the clip window.",
			beats_checked, beats_visible);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
